[hdl/kopl_pkg.sv]
// Package for the keyed object pool: item types, field widths and defaults.
// No dependencies; used by every module of the block through scoped names.
`default_nettype none

package kopl_pkg;

   // Field widths fixed by the item format.
   localparam int KEY_W = 64;
   localparam int HDL_W = 16;
   localparam int CFG_W = 7;

   // Defaults for the top-level parameters.
   localparam int CAPACITY_DEF = 64;
   localparam int HANDLE_BITS_DEF = 16;

   // Reset value of the limit register.
   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 7'd64;

   // Operation codes.
   localparam logic OP_CHECKOUT = 1'b0;
   localparam logic OP_RETURN = 1'b1;

   typedef struct packed {
      logic op;
      logic [KEY_W-1:0] key;
      logic [HDL_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic hit;
      logic [HDL_W-1:0] handle_out;
      logic evicted;
      logic [KEY_W-1:0] evicted_key;
      logic [HDL_W-1:0] evicted_handle;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/kopl_store.sv]
// Entry store of the pool: key and handle memories, one write and one read port.
// Read data is registered. Uses kopl_pkg for the key width.
`default_nettype none

module kopl_store #(
   parameter int DEPTH = 65,
   parameter int AW = 7,
   parameter int HB = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire logic [kopl_pkg::KEY_W-1:0] wr_key,
   input wire logic [HB-1:0] wr_hdl,
   input wire logic rd_en,
   input wire logic [AW-1:0] rd_addr,
   output logic [kopl_pkg::KEY_W-1:0] rd_key,
   output logic [HB-1:0] rd_hdl
);

   logic [kopl_pkg::KEY_W-1:0] key_mem [0:DEPTH-1];
   logic [HB-1:0] hdl_mem [0:DEPTH-1];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         hdl_mem[wr_addr] <= wr_hdl;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key <= key_mem[rd_addr];
         rd_hdl <= hdl_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/keyed_object_pool_lru_core.sv]
// Top level of the keyed object pool with least-recently-returned eviction.
// Depends on kopl_pkg and kopl_store.
//
// Usage:
//   Input: an item (req_data) is taken at a clock edge with start high and
//   busy low. A return item inserts its key and handle as the newest entry;
//   a checkout item looks for the newest entry with the same key, hands out
//   its handle and removes it.
//   Result: exactly one item per input, on rsp_data for one cycle while
//   rsp_valid is high. The receiver cannot stall; it must take it then.
//   Configuration: csr_data is written into the entry limit when csr_valid
//   is high; csr_ready is always high. Write only while busy is low.
// Timing: entries sit oldest first in the store, whose read data is registered.
//   A checkout walks from the newest entry, one entry per cycle, and a
//   removal moves every newer entry down one slot, one per cycle. A return
//   that passes the limit then reads the oldest entry, reports it as evicted
//   and removes it in the same way. busy is high throughout.
// Reset: the pool is empty and the limit is 64; no clearing pass is needed.
`default_nettype none

module keyed_object_pool_lru_core #(
   parameter int CAPACITY = kopl_pkg::CAPACITY_DEF,
   parameter int HANDLE_BITS = kopl_pkg::HANDLE_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire kopl_pkg::req_type req_data,
   output logic rsp_valid,
   output kopl_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [kopl_pkg::CFG_W-1:0] csr_data
);

   localparam int DEPTH = CAPACITY + 1;
   localparam int MW = $clog2(DEPTH);
   localparam int AW = $clog2(CAPACITY + 2);
   localparam int CW = (AW > kopl_pkg::CFG_W) ? AW : kopl_pkg::CFG_W;
   localparam int HW = kopl_pkg::HDL_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_EV_RD = 3'd2;
   localparam logic [2:0] ST_EVICT = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [kopl_pkg::CFG_W-1:0] limit_ff;
   kopl_pkg::req_type req_ff, req_in;
   kopl_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en, rd_en;
   logic [MW-1:0] wr_addr, rd_addr;
   logic [kopl_pkg::KEY_W-1:0] wr_key, rd_key;
   logic [HANDLE_BITS-1:0] wr_hdl, rd_hdl;

   logic [CW-1:0] limit_ext, cap_ext, eff_limit, count_next_ext;
   logic [AW-1:0] count_inc;
   logic [HANDLE_BITS+HW-1:0] hdl_in_ext, hdl_out_ext;
   logic rm_go;
   logic [AW-1:0] rm_pos, rm_pos_inc, idx_inc2;

   kopl_store #(.DEPTH(DEPTH), .AW(MW), .HB(HANDLE_BITS)) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_key(wr_key),
      .wr_hdl(wr_hdl),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_key(rd_key),
      .rd_hdl(rd_hdl)
   );

   // Effective limit: a limit above the capacity acts as the capacity.
   assign limit_ext = CW'(limit_ff);
   assign cap_ext = CW'(CAPACITY);
   assign eff_limit = (limit_ext > cap_ext) ? cap_ext : limit_ext;
   assign count_inc = count_ff + AW'(1);
   assign count_next_ext = CW'(count_inc);

   // Handle width conversion between the ports and the stored width.
   assign hdl_in_ext = {{HANDLE_BITS{1'b0}}, req_data.handle_in};
   assign hdl_out_ext = {{HW{1'b0}}, rd_hdl};

   assign rm_pos_inc = rm_pos + AW'(1);
   assign idx_inc2 = idx_ff + AW'(2);

   // Sequencer: insert, search, evict and close the gap.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = idx_ff[MW-1:0];
      wr_key = rd_key;
      wr_hdl = rd_hdl;
      rd_en = 1'b0;
      rd_addr = '0;
      rm_go = 1'b0;
      rm_pos = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               if (req_data.op == kopl_pkg::OP_RETURN) begin
                  wr_en = 1'b1;
                  wr_addr = count_ff[MW-1:0];
                  wr_key = req_data.key;
                  wr_hdl = hdl_in_ext[HANDLE_BITS-1:0];
                  count_in = count_inc;
                  if (count_next_ext > eff_limit) begin
                     state_in = ST_EV_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = MW'(count_ff - AW'(1));
                  idx_in = count_ff - AW'(1);
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (rd_key == req_ff.key) begin
               rsp_in.hit = 1'b1;
               rsp_in.handle_out = hdl_out_ext[HW-1:0];
               rm_go = 1'b1;
               rm_pos = idx_ff;
            end else if (idx_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_en = 1'b1;
               rd_addr = MW'(idx_ff - AW'(1));
               idx_in = idx_ff - AW'(1);
            end
         end
         ST_EV_RD: begin
            rd_en = 1'b1;
            rd_addr = '0;
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            rsp_in.evicted = 1'b1;
            rsp_in.evicted_key = rd_key;
            rsp_in.evicted_handle = hdl_out_ext[HW-1:0];
            rm_go = 1'b1;
            rm_pos = '0;
         end
         ST_SHIFT: begin
            // Move the entry read last cycle down into slot idx.
            wr_en = 1'b1;
            if (idx_inc2 < count_ff) begin
               rd_en = 1'b1;
               rd_addr = idx_inc2[MW-1:0];
               idx_in = idx_ff + AW'(1);
            end else begin
               count_in = count_ff - AW'(1);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Start removing slot rm_pos: read the next newer entry, if any.
      if (rm_go) begin
         if (rm_pos_inc < count_ff) begin
            rd_en = 1'b1;
            rd_addr = rm_pos_inc[MW-1:0];
            idx_in = rm_pos;
            state_in = ST_SHIFT;
         end else begin
            count_in = count_ff - AW'(1);
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff <= kopl_pkg::MAX_ENTRIES_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   // The pool never holds more than its capacity between items.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff <= AW'(CAPACITY)))
      else $error("entry count above capacity");

   // A result is either a checkout hit or an eviction, never both.
   a_hit_or_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.evicted))
      else $error("result marks both hit and eviction");

   // An accepted item either finishes at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item produced no progress");

   // An eviction only comes from a return item.
   a_evict_on_return: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted) |-> (req_ff.op == kopl_pkg::OP_RETURN))
      else $error("eviction reported for a checkout");

endmodule

`default_nettype wire

[dv/keyed_object_pool_lru_core_test.sv]
// Testbench for keyed_object_pool_lru_core: directed and random checkout and return items,
// checked against an in-bench model of the recency-ordered pool. Depends on kopl_pkg.
`default_nettype none

module keyed_object_pool_lru_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = kopl_pkg::CAPACITY_DEF;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 4 * CAP + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   kopl_pkg::req_type req_data = '0;
   logic rsp_valid;
   kopl_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [kopl_pkg::CFG_W-1:0] csr_data = '0;

   keyed_object_pool_lru_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Pool model, oldest entry in slot 0.
   logic [kopl_pkg::KEY_W-1:0] pool_keys[$];
   logic [kopl_pkg::HDL_W-1:0] pool_handles[$];
   logic [kopl_pkg::CFG_W-1:0] pool_limit = kopl_pkg::MAX_ENTRIES_RESET;

   kopl_pkg::req_type pending_items[$];
   kopl_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int items_sent = 0;
   int rsps_seen = 0;
   int hits_seen = 0;
   int evicts_seen = 0;
   int idle_cycles = 0;
   bit quiet_phase = 1'b0;

   // Compute the result of one accepted item and update the pool.
   function automatic kopl_pkg::rsp_type pool_apply(kopl_pkg::req_type item);
      kopl_pkg::rsp_type r;
      int lim;
      r = '0;
      if (item.op == kopl_pkg::OP_RETURN) begin
         lim = (pool_limit > CAP) ? CAP : pool_limit;
         if (pool_keys.size() <= CAP) begin
            pool_keys.push_back(item.key);
            pool_handles.push_back(item.handle_in);
         end
         if (pool_keys.size() > lim && pool_keys.size() > 0) begin
            r.evicted = 1'b1;
            r.evicted_key = pool_keys.pop_front();
            r.evicted_handle = pool_handles.pop_front();
         end
      end else begin
         for (int i = pool_keys.size() - 1; i >= 0; i--) begin
            if (pool_keys[i] == item.key) begin
               r.hit = 1'b1;
               r.handle_out = pool_handles[i];
               pool_keys.delete(i);
               pool_handles.delete(i);
               break;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [79:0] got, logic [79:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", rsps_seen, what, got, want);
      errors++;
   endtask

   // Driver: one item per start, with random gaps outside the quiet phase.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_rsps.push_back(pool_apply(req_data));
         items_sent++;
         if (pending_items.size() > 0 && (quiet_phase || $urandom_range(99) >= 10)) begin
            req_data <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_items.size() > 0
                   && (quiet_phase || $urandom_range(99) >= 10)) begin
         req_data <= pending_items.pop_front();
         start <= 1'b1;
      end
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      kopl_pkg::rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid || csr_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", 80'(rsp_data.hit), '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.hit) hits_seen++;
               if (rsp_data.evicted) evicts_seen++;
               if (rsp_data.hit !== want.hit)
                  report_mismatch("hit", 80'(rsp_data.hit), 80'(want.hit));
               if (rsp_data.handle_out !== want.handle_out)
                  report_mismatch("handle_out", 80'(rsp_data.handle_out),
                                  80'(want.handle_out));
               if (rsp_data.evicted !== want.evicted)
                  report_mismatch("evicted", 80'(rsp_data.evicted), 80'(want.evicted));
               if (rsp_data.evicted_key !== want.evicted_key)
                  report_mismatch("evicted_key", 80'(rsp_data.evicted_key),
                                  80'(want.evicted_key));
               if (rsp_data.evicted_handle !== want.evicted_handle)
                  report_mismatch("evicted_handle", 80'(rsp_data.evicted_handle),
                                  80'(want.evicted_handle));
            end
         end
      end
   end

   // Watchdog on cycles with no handshake at all.
   always @(posedge clock) begin
      if (idle_cycles > IDLE_LIMIT) begin
         $display("keyed_object_pool_lru_core_test failed");
         $finish;
      end
   end

   function automatic kopl_pkg::req_type make_item(logic op,
                                                   logic [kopl_pkg::KEY_W-1:0] key,
                                                   logic [kopl_pkg::HDL_W-1:0] hdl);
      kopl_pkg::req_type t;
      t.op = op;
      t.key = key;
      t.handle_in = hdl;
      return t;
   endfunction

   // Keys drawn from a small set so checkouts hit often, with some full-width noise.
   function automatic logic [kopl_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(9) < 8) return {32'hA5A5_0000, 28'h0, 4'($urandom_range(7))};
      return {$urandom, $urandom};
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [kopl_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pool_limit = value;
   endtask

   task automatic random_phase(int count, int return_pct);
      for (int i = 0; i < count; i++) begin
         pending_items.push_back(make_item(($urandom_range(99) < return_pct)
                                           ? kopl_pkg::OP_RETURN : kopl_pkg::OP_CHECKOUT,
                                           pick_key(), 16'($urandom)));
      end
   endtask

   initial begin
      logic [kopl_pkg::CFG_W-1:0] limits[6];
      limits = '{7'd3, 7'd0, 7'd1, 7'd127, 7'd64, 7'd20};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty checkout, extremes, duplicate keys, a run of returns at reset limit.
      pending_items.push_back(make_item(kopl_pkg::OP_CHECKOUT, '0, '0));
      pending_items.push_back(make_item(kopl_pkg::OP_RETURN, '1, '1));
      pending_items.push_back(make_item(kopl_pkg::OP_RETURN, '0, '0));
      pending_items.push_back(make_item(kopl_pkg::OP_RETURN, '1, 16'h1234));
      pending_items.push_back(make_item(kopl_pkg::OP_CHECKOUT, '1, '1));
      pending_items.push_back(make_item(kopl_pkg::OP_CHECKOUT, '1, '0));
      pending_items.push_back(make_item(kopl_pkg::OP_CHECKOUT, '0, '1));
      pending_items.push_back(make_item(kopl_pkg::OP_CHECKOUT, 64'h5, '0));
      for (int i = 0; i < 16; i++)
         pending_items.push_back(make_item(kopl_pkg::OP_RETURN, 64'(i), 16'(i)));
      wait_drained();
      // Lower the limit below the count: each insert then evicts the oldest entry.
      write_limit(7'd2);
      pending_items.push_back(make_item(kopl_pkg::OP_RETURN, 64'h77, 16'h77));
      pending_items.push_back(make_item(kopl_pkg::OP_CHECKOUT, 64'h77, '0));
      wait_drained();

      // Random phases over several limits; a quiet phase with no gaps in the middle.
      foreach (limits[n]) begin
         write_limit(limits[n]);
         quiet_phase = (n == 3);
         random_phase((limits[n] >= 64) ? 400 : 220, (n % 2 == 0) ? 60 : 50);
         wait_drained();
      end
      quiet_phase = 1'b0;

      $display("ran %0d items over %0d limit settings: %0d hits, %0d evictions",
               items_sent, 7, hits_seen, evicts_seen);
      if (errors == 0) begin
         $display("keyed_object_pool_lru_core_test passed");
      end else begin
         $display("keyed_object_pool_lru_core_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
